@@ rtl/cfsu_pkg.sv @@
// ---------------------------------------------------------------------------
// cfsu_pkg
// Types, command codes and helpers for the first-seen character histogram.
// ---------------------------------------------------------------------------
package cfsu_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 32;
    localparam int DIST_W  = 9;
    localparam int SLOT_W  = CHAR_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        CMD_COUNT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_FIN
    } t_state;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] f;
        f = b;
        if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
            f = b + CASE_OFFSET;
        end
        return f;
    endfunction

endpackage

@@ rtl/cfsu_ram.sv @@
// ---------------------------------------------------------------------------
// cfsu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module cfsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/char_frequency_first_seen_unit.sv @@
// ---------------------------------------------------------------------------
// char_frequency_first_seen_unit
// Character histogram with slots kept in order of first appearance.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one command word: count a byte,
//   read a slot, or clear the table. Output channel (o_valid / i_ready)
//   returns exactly one result word per command, in order.
//   A count issues the map RAM read of the folded byte in the accept
//   cycle, then the slot RAM read at the slot it names, then compare and
//   write back. Read, clear and the unused code do one slot RAM read, or
//   none, then the result step. One command is in flight at a time; the
//   next is taken the cycle after its result is loaded into the output
//   register. Reset clears the state, the fill count and the output valid
//   only. RAM contents are never trusted: a map entry counts as a hit only
//   if it points below the fill count and that slot holds the same character,
//   so no clearing pass is needed and clear is a single step.
//   Receiver stall: while the output register is full and not taken, the
//   command in flight waits at its final step, nothing is written, and
//   o_ready stays low.
// ---------------------------------------------------------------------------
module char_frequency_first_seen_unit
    import cfsu_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command word
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_cmd,
    input  logic [CHAR_W-1:0]   i_byte_value,
    input  logic [7:0]          i_slot_index,
    // result word
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_entry_char,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic                o_entry_valid,
    output logic [DIST_W-1:0]   o_distinct_count
);

    localparam int SW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW       = $clog2(TABLE_DEPTH + 1);
    localparam int MAP_SIZE = 1 << CHAR_W;
    localparam logic [DIST_W-1:0] DEPTH_D = DIST_W'(TABLE_DEPTH);

    // control state
    t_state          r_state, n_state;
    logic [UW-1:0]   r_used, n_used;
    logic            r_o_valid;

    // latched command
    t_cmd            r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic [7:0]      r_idx;

    // result payload
    logic [CHAR_W-1:0]  r_o_char, n_o_char;
    logic [COUNT_W-1:0] r_o_count, n_o_count;
    logic               r_o_evalid, n_o_evalid;
    logic [DIST_W-1:0]  r_o_dist;

    // RAM ports
    logic              map_we, map_re;
    logic [CHAR_W-1:0] map_waddr, map_raddr;
    logic [SW-1:0]     map_wdata, map_q;
    logic              slot_we, slot_re;
    logic [SW-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_W-1:0] slot_wdata, slot_q;

    logic              accept, fin_go, out_free;
    logic              look_sel;
    logic              hit, full, idx_ok;
    logic [CHAR_W-1:0] q_char;
    logic [COUNT_W-1:0] q_count, sat_count;

    // char -> slot map, indexed by folded byte
    cfsu_ram #(.WIDTH(SW), .DEPTH(MAP_SIZE), .AW(CHAR_W)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_q)
    );

    // slot store: {char, count} in first-seen order
    cfsu_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH), .AW(SW)) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_q)
    );

    assign out_free = !r_o_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign fin_go   = (r_state == ST_FIN) && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (t_cmd'(i_cmd) == CMD_COUNT) ? ST_LOOK : ST_FIN;
                end
            end
            ST_LOOK: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready  = 1'b0;
        look_sel = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready  = 1'b1;
            ST_LOOK: look_sel = 1'b1;
            ST_FIN:  ;
            default: ;
        endcase
    end

    // read side: map read at accept, slot read at accept (read cmd) or in LOOK
    assign map_re     = accept;
    assign map_raddr  = fold_case(i_byte_value);
    assign slot_re    = look_sel || (accept && t_cmd'(i_cmd) == CMD_READ);
    assign slot_raddr = look_sel ? map_q : i_slot_index[SW-1:0];

    assign q_char    = slot_q[SLOT_W-1 -: CHAR_W];
    assign q_count   = slot_q[COUNT_W-1:0];
    assign sat_count = (q_count == COUNT_MAX) ? q_count : q_count + COUNT_ONE;

    // hit only if the map entry points into the live part and agrees
    assign hit    = (DIST_W'(map_q) < DIST_W'(r_used)) && (q_char == r_char);
    assign full   = (DIST_W'(r_used) == DEPTH_D);
    assign idx_ok = (DIST_W'(r_idx) < DIST_W'(r_used)) && (DIST_W'(r_idx) < DEPTH_D);

    // result step: write back and form the result word
    always_comb begin
        map_we     = 1'b0;
        map_waddr  = r_char;
        map_wdata  = r_used[SW-1:0];
        slot_we    = 1'b0;
        slot_waddr = map_q;
        slot_wdata = {r_char, sat_count};
        n_used     = r_used;
        n_o_char   = '0;
        n_o_count  = '0;
        n_o_evalid = 1'b0;
        case (r_cmd)
            CMD_COUNT: begin
                n_o_char = r_char;
                if (hit) begin
                    slot_we    = fin_go;
                    n_o_count  = sat_count;
                    n_o_evalid = 1'b1;
                end else if (!full) begin
                    slot_we    = fin_go;
                    slot_waddr = r_used[SW-1:0];
                    slot_wdata = {r_char, COUNT_ONE};
                    map_we     = fin_go;
                    n_used     = r_used + UW'(1);
                    n_o_count  = COUNT_ONE;
                    n_o_evalid = 1'b1;
                end
            end
            CMD_READ: begin
                if (idx_ok) begin
                    n_o_char   = q_char;
                    n_o_count  = q_count;
                    n_o_evalid = 1'b1;
                end
            end
            CMD_CLEAR: n_used = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_used    <= n_used;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_char <= fold_case(i_byte_value);
            r_idx  <= i_slot_index;
        end
        if (fin_go) begin
            r_o_char   <= n_o_char;
            r_o_count  <= n_o_count;
            r_o_evalid <= n_o_evalid;
            r_o_dist   <= DIST_W'(n_used);
        end
    end

    assign o_valid          = r_o_valid;
    assign o_entry_char     = r_o_char;
    assign o_entry_count    = r_o_count;
    assign o_entry_valid    = r_o_evalid;
    assign o_distinct_count = r_o_dist;

endmodule

@@ dv/char_frequency_first_seen_unit_tb.sv @@
// ---------------------------------------------------------------------------
// char_frequency_first_seen_unit_tb
// Self-checking bench for the first-seen character histogram. Command words
// go in through a valid/ready driver. A histogram model inside the bench
// predicts each result word. A monitor on the result channel compares every
// word field by field against the oldest prediction. Both channels idle at
// random, apart from planned stretches with no idling and a long receiver
// hold-off.
// ---------------------------------------------------------------------------
module char_frequency_first_seen_unit_tb;
    import cfsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 256;
    localparam int RANDOM_WORDS = 1100;
    localparam int MAX_PRINTS   = 25;

    // result word as the monitor sees it
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] cnt;
        logic               vld;
        logic [DIST_W-1:0]  dcnt;
    } t_hist_result;

    // ---- DUT ports; all inputs start at known values ----
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_ready;
    logic [1:0]         i_cmd        = CMD_NOP;
    logic [CHAR_W-1:0]  i_byte_value = '0;
    logic [7:0]         i_slot_index = '0;
    logic               o_valid;
    logic               i_ready      = 1'b0;
    logic [CHAR_W-1:0]  o_entry_char;
    logic [COUNT_W-1:0] o_entry_count;
    logic               o_entry_valid;
    logic [DIST_W-1:0]  o_distinct_count;

    // ---- histogram model state, mirrors what the block should hold ----
    logic [CHAR_W-1:0]  hist_chars  [TABLE_DEPTH];
    logic [COUNT_W-1:0] hist_counts [TABLE_DEPTH];
    int                 hist_fill;

    // results predicted and not yet seen on the output
    t_hist_result pending_results[$];

    // flow control between test tasks and the channel processes
    bit steady_flow;   // no random idling on either side while set
    int rx_hold;       // cycles the receiver still holds i_ready low

    // bookkeeping
    int mismatches;
    int words_sent;
    int words_checked;
    int peak_distinct;
    int cmd_tally[4];

    char_frequency_first_seen_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_byte_value     (i_byte_value),
        .i_slot_index     (i_slot_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_entry_char     (o_entry_char),
        .o_entry_count    (o_entry_count),
        .o_entry_valid    (o_entry_valid),
        .o_distinct_count (o_distinct_count)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ---- mismatch reporting: one line each, printing capped ----
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // ---- histogram model ----
    // Fold A-Z to lower case, then update or read the table. Every
    // command yields exactly one result word.
    function automatic t_hist_result predict_histogram(input t_cmd cmd,
                                                       input logic [7:0] raw,
                                                       input logic [7:0] idx);
        t_hist_result r;
        logic [CHAR_W-1:0] f;
        bit hit;
        r   = '0;
        f   = raw;
        hit = 1'b0;
        if (raw >= UPPER_FIRST && raw <= UPPER_LAST) begin
            f = raw + CASE_OFFSET;
        end
        case (cmd)
            CMD_COUNT: begin
                r.ch = f;
                for (int i = 0; i < hist_fill; i++) begin
                    if (!hit && hist_chars[i] == f) begin
                        if (hist_counts[i] != COUNT_MAX) begin
                            hist_counts[i] = hist_counts[i] + 1'b1;
                        end
                        r.cnt = hist_counts[i];
                        r.vld = 1'b1;
                        hit   = 1'b1;
                    end
                end
                // new character: next free slot, or dropped when full
                if (!hit && hist_fill < TABLE_DEPTH) begin
                    hist_chars[hist_fill]  = f;
                    hist_counts[hist_fill] = COUNT_ONE;
                    hist_fill++;
                    r.cnt = COUNT_ONE;
                    r.vld = 1'b1;
                end
            end
            CMD_READ: begin
                if (int'(idx) < hist_fill) begin
                    r.ch  = hist_chars[idx];
                    r.cnt = hist_counts[idx];
                    r.vld = 1'b1;
                end
            end
            CMD_CLEAR: begin
                hist_fill = 0;
            end
            default: begin
            end
        endcase
        r.dcnt = DIST_W'(hist_fill);
        if (hist_fill > peak_distinct) begin
            peak_distinct = hist_fill;
        end
        return r;
    endfunction

    // ---- sender: one command word per call ----
    // Valid stays high after acceptance so back-to-back words need no
    // drop; any gap or pause lowers it first.
    task automatic send_word(input t_cmd cmd, input logic [7:0] raw,
                             input logic [7:0] idx);
        if (!steady_flow) begin
            while ($urandom_range(99) < 7) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_byte_value <= raw;
        i_slot_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_histogram(cmd, raw, idx));
        words_sent++;
        cmd_tally[cmd]++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ---- receiver and result checker ----
    // Outputs are read right after the edge, i.e. the values that were
    // sampled at it. i_ready is redrawn every cycle.
    initial begin
        t_hist_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result char=%h count=%0d",
                                              o_entry_char, o_entry_count));
                end else begin
                    want = pending_results.pop_front();
                    words_checked++;
                    if (o_entry_char !== want.ch)
                        report_mismatch($sformatf("entry_char got %h want %h",
                                                  o_entry_char, want.ch));
                    if (o_entry_count !== want.cnt)
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                                                  o_entry_count, want.cnt));
                    if (o_entry_valid !== want.vld)
                        report_mismatch($sformatf("entry_valid got %b want %b",
                                                  o_entry_valid, want.vld));
                    if (o_distinct_count !== want.dcnt)
                        report_mismatch($sformatf("distinct_count got %0d want %0d",
                                                  o_distinct_count, want.dcnt));
                end
            end
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if (steady_flow) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 7);
            end
        end
    end

    // ---- tests ----

    // Edges of the byte field, case folding boundaries, every command,
    // reads past the fill point, and clear followed by reuse of slot 0.
    task automatic test_directed();
        send_word(CMD_READ,  8'h00, 8'd0);     // empty table
        send_word(CMD_READ,  8'h00, 8'd255);
        send_word(CMD_NOP,   8'hFF, 8'hFF);
        send_word(CMD_COUNT, 8'h41, 8'h00);    // 'A' -> 'a', new slot
        send_word(CMD_COUNT, 8'h61, 8'h00);    // 'a' hits same slot
        send_word(CMD_COUNT, 8'h5A, 8'h00);    // 'Z' -> 'z'
        send_word(CMD_COUNT, 8'h7A, 8'h00);    // 'z' hit
        send_word(CMD_COUNT, 8'h40, 8'h00);    // '@' just below A, not folded
        send_word(CMD_COUNT, 8'h5B, 8'h00);    // '[' just above Z, not folded
        send_word(CMD_COUNT, 8'h00, 8'h00);
        send_word(CMD_COUNT, 8'hFF, 8'h00);
        send_word(CMD_COUNT, 8'hDA, 8'h00);    // high bit set, no fold
        send_word(CMD_READ,  8'h00, 8'd0);
        send_word(CMD_READ,  8'h00, 8'd1);
        send_word(CMD_READ,  8'h00, 8'd6);     // last used slot
        send_word(CMD_READ,  8'h00, 8'd7);     // first unused slot
        send_word(CMD_READ,  8'h00, 8'd255);
        send_word(CMD_NOP,   8'h41, 8'd0);
        send_word(CMD_CLEAR, 8'h00, 8'd0);
        send_word(CMD_READ,  8'h00, 8'd0);     // stale slot must read empty
        send_word(CMD_COUNT, 8'h5A, 8'h00);    // stale 'z' must not hit
        send_word(CMD_READ,  8'h00, 8'd0);
        send_word(CMD_CLEAR, 8'hFF, 8'hFF);
        wait_drained();
    endtask

    // Count every byte value once in shuffled order, with no idling. Only
    // 230 distinct folded values exist, so the table tops out there; a
    // count on a truly full table cannot be reached at this depth.
    task automatic test_fill_table();
        logic [7:0] order [256];
        logic [7:0] tmp;
        int j;
        for (int i = 0; i < 256; i++) order[i] = 8'(i);
        for (int i = 255; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        steady_flow = 1'b1;
        for (int i = 0; i < 256; i++) send_word(CMD_COUNT, order[i], 8'($urandom));
        for (int i = 0; i < 256; i++) send_word(CMD_READ, 8'($urandom), 8'(i));
        steady_flow = 1'b0;
        // hits on a full-ish table, both letter cases
        for (int i = 0; i < 60; i++) send_word(CMD_COUNT, 8'($urandom), 8'h00);
        wait_drained();
    endtask

    // Text-like traffic: mostly letters with some punctuation and raw
    // bytes, reads mostly inside the filled region, rare clears.
    task automatic test_random_text();
        int pick;
        logic [7:0] ch;
        logic [7:0] idx;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                case ($urandom_range(9))
                    0:       ch = 8'($urandom);                    // any byte
                    1:       ch = 8'h20 + 8'($urandom_range(31));  // space, digits
                    2, 3, 4: ch = 8'h41 + 8'($urandom_range(25));  // upper case
                    default: ch = 8'h61 + 8'($urandom_range(25));  // lower case
                endcase
                send_word(CMD_COUNT, ch, 8'($urandom));
            end else if (pick < 95) begin
                if (hist_fill > 0 && $urandom_range(9) < 8)
                    idx = 8'($urandom_range(hist_fill - 1));
                else
                    idx = 8'($urandom);
                send_word(CMD_READ, 8'($urandom), idx);
            end else if (pick < 97) begin
                send_word(CMD_CLEAR, 8'($urandom), 8'($urandom));
            end else begin
                send_word(CMD_NOP, 8'($urandom), 8'($urandom));
            end
        end
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps
    // offering words, so the block backs up and drops o_ready. Then the
    // sender pauses until all results are in, and resumes.
    task automatic test_backpressure();
        rx_hold     = 400;
        steady_flow = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_word(($urandom_range(3) == 0) ? CMD_READ : CMD_COUNT,
                      8'h61 + 8'($urandom_range(25)), 8'($urandom_range(15)));
        end
        steady_flow = 1'b0;
        wait_drained();
        for (int i = 0; i < 20; i++) begin
            send_word(t_cmd'($urandom_range(1)), 8'h41 + 8'($urandom_range(25)),
                      8'($urandom_range(31)));
        end
        wait_drained();
    endtask

    // ---- main sequence ----
    initial begin
        hist_fill     = 0;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        peak_distinct = 0;
        rx_hold       = 0;
        steady_flow   = 1'b0;
        for (int i = 0; i < 4; i++) cmd_tally[i] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_table();
        test_random_text();
        test_backpressure();

        // let any stray result show up before closing out
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_results.size()));

        $display("covered %0d words: %0d counts, %0d reads, %0d clears, %0d unused codes",
                 words_sent, cmd_tally[CMD_COUNT], cmd_tally[CMD_READ],
                 cmd_tally[CMD_CLEAR], cmd_tally[CMD_NOP]);
        $display("checked %0d results, peak distinct %0d, %0d mismatches",
                 words_checked, peak_distinct, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ char_frequency_first_seen_unit.f @@
rtl/cfsu_pkg.sv
rtl/cfsu_ram.sv
rtl/char_frequency_first_seen_unit.sv
dv/char_frequency_first_seen_unit_tb.sv
